[sv/lru_key_value_cache_assert.svh]
// ---------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// condition implies consequence in the same cycle
`define LKV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/lkv_pkg.sv]
// ---------------------------------------------------------------------------
// lkv_pkg
// shared types and constants for the lru key-value cache
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkv_pkg;

  // default sizes
  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_KEY_BITS   = 32;
  localparam int DEF_VALUE_BITS = 32;

  // capacity register
  localparam int             CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // request kind
  typedef enum logic {
    KIND_GET = 1'b0,
    KIND_PUT = 1'b1
  } kind_e;

endpackage

[sv/lkv_store.sv]
// ---------------------------------------------------------------------------
// lkv_store
// entry storage with parallel key compare, lru ranks and single-pass update
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "lru_key_value_cache_assert.svh"

module lkv_store #(
  parameter int ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_i,
  input  lkv_pkg::kind_e              kind_i,
  input  logic [KEY_BITS-1:0]         key_i,
  input  logic [VALUE_BITS-1:0]       value_i,
  input  logic [lkv_pkg::CAP_BITS-1:0] cap_i,
  output logic                        found_o,
  output logic [VALUE_BITS-1:0]       read_value_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CAP_W  = lkv_pkg::CAP_BITS;
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // state
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];
  logic [IDX_W-1:0]      rank_q  [ENTRIES];
  logic [IDX_W-1:0]      rank_d  [ENTRIES];

  // lookup
  logic [ENTRIES-1:0] hit_vec;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;

  // replacement
  logic [CMP_W-1:0]   cap_eff;
  logic               evict;
  logic [OCC_W-1:0]   occ_m1;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] valid_left;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;

  // request decode
  logic touch;
  logic insert;
  logic put_hit;

  // parallel key compare against every valid entry
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == key_i);
    end
  end

  // lowest matching entry
  always_comb begin
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign hit_rank = rank_q[hit_idx];

  // effective capacity, clamped to one .. ENTRIES
  always_comb begin
    cap_eff = CMP_W'(cap_i);
    if (cap_eff == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign touch   = req_i && hit;
  assign put_hit = req_i && hit && (kind_i == lkv_pkg::KIND_PUT);
  assign evict   = req_i && !hit && (kind_i == lkv_pkg::KIND_PUT) &&
                   (CMP_W'(occ_q) >= cap_eff) && (occ_q != '0);
  assign occ_m1  = occ_q - OCC_W'(1);

  // least recent entry holds the highest rank, occupancy minus one
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict_vec[i] = evict && valid_q[i] && (rank_q[i] == occ_m1[IDX_W-1:0]);
    end
  end

  assign valid_left = valid_q & ~evict_vec;

  // lowest free entry after any eviction
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_left[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign insert = req_i && !hit && (kind_i == lkv_pkg::KIND_PUT) && free_found;

  // next ranks, valid bits and occupancy
  always_comb begin
    valid_d = valid_left;
    occ_d   = occ_q - OCC_W'(|evict_vec);
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (touch) begin
        if (IDX_W'(i) == hit_idx) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end else if (insert) begin
        if (IDX_W'(i) == free_idx) begin
          rank_d[i] = '0;
        end else if (valid_left[i]) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
    end
    if (insert) begin
      valid_d[free_idx] = 1'b1;
      occ_d             = occ_d + OCC_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (req_i) begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
    end
  end

  // entry payload and ranks
  always_ff @(posedge clk_i) begin
    if (req_i) begin
      rank_q <= rank_d;
    end
    if (insert) begin
      key_q[free_idx]   <= key_i;
      value_q[free_idx] <= value_i;
    end else if (put_hit) begin
      value_q[hit_idx] <= value_i;
    end
  end

  // result
  assign found_o      = hit;
  assign read_value_o = (hit && (kind_i == lkv_pkg::KIND_GET)) ? value_q[hit_idx] : '0;

  // checks
  `LKV_ASSERT_NOW(occ_matches_valid_a, 1'b1, $countones(valid_q) == int'(occ_q), "occupancy differs from valid count")
  `LKV_ASSERT_NOW(single_hit_a, req_i, $onehot0(hit_vec), "key held by more than one entry")
  `LKV_ASSERT_NOW(put_miss_slot_a, req_i && !hit && (kind_i == lkv_pkg::KIND_PUT), free_found, "put miss without a free entry")
  `LKV_ASSERT_NOW(evict_one_a, evict, $onehot(evict_vec), "eviction does not select exactly one entry")

endmodule

[sv/lru_key_value_cache.sv]
// ---------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value cache with least-recently-used replacement
// ---------------------------------------------------------------------------
// Returns exactly one result per get or put request, in request order, from
// the result register. Each request is registered, then compared against
// every entry in parallel; the recency ranks, valid bits and entry stores are
// updated in the same cycle as the result is registered. This compare and
// rank update loop sets the rate of one request per clock while the result
// channel does not stall. A put miss with the cache at capacity first evicts
// the least recent entry. The user must write the capacity register through
// cfg_we_i / cfg_wdata_i only while the cache is idle, unchecked by the block.
`timescale 1ns / 1ps

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache #(
  parameter int ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         kind_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         found_o,
  output logic [VALUE_BITS-1:0]        read_value_o,
  // capacity register
  input  logic                         cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0] cfg_wdata_i
);

  // input register
  logic                  in_valid_q;
  logic                  kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // result register
  logic                  out_valid_q;
  logic                  found_q;
  logic [VALUE_BITS-1:0] read_value_q;

  // capacity
  logic [lkv_pkg::CAP_BITS-1:0] cap_q;

  // store results
  logic                  st_found;
  logic [VALUE_BITS-1:0] st_read_value;

  logic consume;

  // request is processed when the result register is free or draining
  assign consume    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || consume;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

  // entry store and lookup
  lkv_store #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (consume),
    .kind_i       (lkv_pkg::kind_e'(kind_q)),
    .key_i        (key_q),
    .value_i      (value_q),
    .cap_i        (cap_q),
    .found_o      (st_found),
    .read_value_o (st_read_value)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (consume) begin
      found_q      <= st_found;
      read_value_q <= st_read_value;
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = found_q;
  assign read_value_o = read_value_q;

  // checks
  `LKV_ASSERT_NEXT(result_after_process_a, consume, out_valid_q, "processed request left no result")
  `LKV_ASSERT_NEXT(request_held_a, in_valid_q && !consume, in_valid_q && $stable(key_q), "pending request lost")

endmodule

[test/lru_key_value_cache_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lru_key_value_cache_tb
// self-checking bench for the lru key-value cache
// ---------------------------------------------------------------------------
// Drives get and put requests over the valid/ready request channel and
// keeps its own copy of the cache contents and recency order. Every result
// transfer is compared, field by field, with the oldest outstanding
// prediction. Directed tests cover field extremes, hits, misses, updates,
// least-recent eviction and the capacity corner cases. A randomised section
// then runs several phases with different capacity settings and sender and
// receiver idling, drawing most keys from a small pool so that hits,
// updates and evictions are frequent.

module lru_key_value_cache_tb;
  import lkv_pkg::*;

  localparam int ENTRIES        = DEF_ENTRIES;
  localparam int KEY_BITS       = DEF_KEY_BITS;
  localparam int VALUE_BITS     = DEF_VALUE_BITS;
  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_PRINTS     = 40;
  localparam int KEY_POOL_SIZE  = 24;
  localparam int PHASE_ITEMS    = 160;
  localparam int RANDOM_PHASES  = 8;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct {
    logic   found;
    value_t read_value;
  } cache_result_t;

  // dut ports
  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                kind_i;
  key_t                key_i;
  value_t              value_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                found_o;
  value_t              read_value_o;
  logic                cfg_we_i;
  logic [CAP_BITS-1:0] cfg_wdata_i;

  // predicted cache contents
  bit                  line_valid [ENTRIES];
  key_t                line_key   [ENTRIES];
  value_t              line_value [ENTRIES];
  int unsigned         line_rank  [ENTRIES];
  int unsigned         line_count;
  logic [CAP_BITS-1:0] capacity_reg;

  // results still owed by the cache, oldest first
  cache_result_t       pending_results [$];

  // run bookkeeping
  int                  error_count;
  int                  cycle_count;
  int                  send_idle_pct;
  int                  recv_stall_pct;
  int                  n_gets;
  int                  n_puts;
  int                  n_hits;
  int                  n_evictions;
  int                  n_checked;
  key_t                key_pool [KEY_POOL_SIZE];

  lru_key_value_cache #(
    .ENTRIES   (ENTRIES),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .read_value_o(read_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lru_key_value_cache verification failed");
      $finish;
    end
  end

  // result channel back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // result transfers checked against the oldest prediction
  always @(posedge clk_i) begin
    cache_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (found_o !== want.found) begin
          report_mismatch($sformatf("result %0d found %b, predicted %b",
                                    n_checked, found_o, want.found));
        end
        if (read_value_o !== want.read_value) begin
          report_mismatch($sformatf("result %0d read_value %h, predicted %h",
                                    n_checked, read_value_o, want.read_value));
        end
      end
    end
  end

  // capacity as the cache applies it: zero acts as one, saturates at the size
  function automatic int unsigned usable_capacity();
    int unsigned cap;
    cap = capacity_reg;
    if (cap < 1) cap = 1;
    if (cap > ENTRIES) cap = ENTRIES;
    return cap;
  endfunction

  // make one line most recent, ageing those that were more recent
  function automatic void promote_line(input int unsigned slot);
    int unsigned old_rank;
    old_rank = line_rank[slot];
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && i != slot && line_rank[i] < old_rank) line_rank[i]++;
    end
    line_rank[slot] = 0;
  endfunction

  // apply one accepted request to the predicted contents and queue its result
  function automatic void predict_lookup(input kind_e kind, input key_t key,
                                         input value_t value);
    cache_result_t res;
    int            hit_slot;
    int            victim;
    int            free_slot;
    int unsigned   worst_rank;
    hit_slot   = -1;
    victim     = -1;
    free_slot  = -1;
    worst_rank = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_key[i] == key) begin
        hit_slot = i;
        break;
      end
    end
    res.found      = (hit_slot >= 0);
    res.read_value = '0;
    if (res.found) n_hits++;

    if (kind == KIND_GET) begin
      n_gets++;
      if (res.found) begin
        res.read_value = line_value[hit_slot];
        promote_line(hit_slot);
      end
    end else if (res.found) begin
      n_puts++;
      line_value[hit_slot] = value;
      promote_line(hit_slot);
    end else begin
      n_puts++;
      // full (or over-full after a lowered capacity): drop the least recent
      if (line_count >= usable_capacity() && line_count > 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && (victim < 0 || line_rank[i] > worst_rank)) begin
            victim     = i;
            worst_rank = line_rank[i];
          end
        end
        line_valid[victim] = 1'b0;
        line_count--;
        n_evictions++;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (!line_valid[i]) begin
          free_slot = i;
          break;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i]) line_rank[i]++;
      end
      line_valid[free_slot] = 1'b1;
      line_key[free_slot]   = key;
      line_value[free_slot] = value;
      line_rank[free_slot]  = 0;
      line_count++;
    end
    pending_results.push_back(res);
  endfunction

  // one request transfer, followed by an optional sender gap
  task automatic send_request(input kind_e kind, input key_t key, input value_t value);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    key_i      <= key;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predict_lookup(kind, key, value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_cache();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // capacity register write, only with the cache idle
  task automatic set_capacity(input logic [CAP_BITS-1:0] cap);
    settle_cache();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    capacity_reg = cap;
  endtask

  // field extremes, hits, misses and overwrites at the reset capacity
  task automatic test_basic_access();
    send_request(KIND_GET, '0, '1);
    send_request(KIND_PUT, '0, '0);
    send_request(KIND_PUT, '1, '1);
    send_request(KIND_GET, '0, '1);
    send_request(KIND_GET, '1, '0);
    send_request(KIND_PUT, '1, 32'h0000_1234);
    send_request(KIND_GET, '1, '0);
    send_request(KIND_GET, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    settle_cache();
  endtask

  // least-recent choice of victim with two lines in use
  task automatic test_lru_order();
    set_capacity(5'd2);
    send_request(KIND_PUT, 32'hA5A5_A5A5, 32'h1111_0000);
    send_request(KIND_GET, '0, '0);
    send_request(KIND_GET, '1, '0);
    send_request(KIND_PUT, 32'h3C3C_3C3C, 32'h2222_0000);
    send_request(KIND_GET, 32'hA5A5_A5A5, '0);
    send_request(KIND_GET, 32'h3C3C_3C3C, '0);
    settle_cache();
  endtask

  // capacity zero acting as one while over-full, then a saturating capacity
  task automatic test_capacity_limits();
    set_capacity(5'd0);
    send_request(KIND_PUT, 32'h1111_1111, 32'hDEAD_BEEF);
    send_request(KIND_PUT, 32'h2222_2222, 32'hCAFE_F00D);
    send_request(KIND_GET, 32'h1111_1111, '0);
    set_capacity(5'd31);
    send_request(KIND_PUT, 32'h8000_0001, 32'h7FFF_FFFE);
    send_request(KIND_PUT, 32'h0000_0080, 32'h8000_0000);
    send_request(KIND_GET, 32'h2222_2222, '0);
    settle_cache();
  endtask

  // randomised traffic over several capacity and idling phases
  task automatic test_random_traffic();
    int   span;
    kind_e kind;
    key_t key;
    value_t value;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      case (phase)
        0:       set_capacity(5'd16);
        1:       set_capacity(5'd31);
        2:       set_capacity(5'd4);
        3:       set_capacity(5'd1);
        4:       set_capacity(5'd12);
        5:       set_capacity(5'd0);
        6:       set_capacity(5'd17);
        default: set_capacity(5'd2);
      endcase
      span = usable_capacity() + 3;
      if (span > KEY_POOL_SIZE) span = KEY_POOL_SIZE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind  = kind_e'($urandom_range(0, 1));
        key   = ($urandom_range(0, 99) < 80) ? key_pool[$urandom_range(0, span - 1)]
                                             : key_t'($urandom());
        value = $urandom();
        send_request(kind, key, value);
      end
      settle_cache();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = 1'b0;
    key_i          = '0;
    value_i        = '0;
    out_ready_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    n_gets         = 0;
    n_puts         = 0;
    n_hits         = 0;
    n_evictions    = 0;
    n_checked      = 0;
    line_count     = 0;
    capacity_reg   = CAP_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = 0;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_access();
    test_lru_order();
    test_capacity_limits();
    test_random_traffic();
    settle_cache();

    $display("checked %0d results: %0d gets, %0d puts, %0d hits, %0d evictions",
             n_checked, n_gets, n_puts, n_hits, n_evictions);
    $display("capacities 0, 1, 2, 4, 12, 16, 17 and 31 under four idling mixes");
    if (error_count == 0) begin
      $display("lru_key_value_cache verification clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("lru_key_value_cache verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/lkv_pkg.sv
sv/lkv_store.sv
sv/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
